// File: hdl/triangle_tile_binner_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the triangle tile binner
// Shorthand for clocked properties sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_TILE_BINNER_CORE_MACROS_SVH
`define TRIANGLE_TILE_BINNER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TTB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TTB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ttb_pkg.sv
// ----------------------------------------------------------------------------
// Triangle tile binner package
// Word types, register codes, state encoding and fixed constants.
// ----------------------------------------------------------------------------
`default_nettype none

package ttb_pkg;

  localparam int COORD_W   = 24;
  localparam int FRAC_BITS = 24;
  localparam int INV_W     = 24;
  localparam int MUL_W     = COORD_W + INV_W;
  localparam int DIM_REG_W = 11;
  localparam int TILE_W    = 20;
  localparam int FACET_W   = 16;
  localparam int NUM_SLOTS = 6;
  localparam int SLOT_W    = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [3:0] OC_LEFT  = 4'b0001;
  localparam logic [3:0] OC_BELOW = 4'b0010;
  localparam logic [3:0] OC_RIGHT = 4'b0100;
  localparam logic [3:0] OC_ABOVE = 4'b1000;

  localparam logic [1:0] EDGE_VERTEX [6] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH    = 2'd0,
    CFG_GRID_HEIGHT   = 2'd1,
    CFG_INV_CELL_SIZE = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CLAMP,
    S_BASE,
    S_SETUP,
    S_WALK,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic [FACET_W-1:0] facet_index;
    logic [COORD_W-1:0] v0_x;
    logic [COORD_W-1:0] v0_z;
    logic [COORD_W-1:0] v1_x;
    logic [COORD_W-1:0] v1_z;
    logic [COORD_W-1:0] v2_x;
    logic [COORD_W-1:0] v2_z;
  } tri_word_t;

  typedef struct packed {
    logic [TILE_W-1:0]  tile_index;
    logic [FACET_W-1:0] owner_facet;
    logic               last_tile;
    logic               span_overflow;
  } tile_word_t;

endpackage

`default_nettype wire

// File: hdl/triangle_tile_binner_core.sv
// ----------------------------------------------------------------------------
// Triangle tile binner core
// Scales a ground-plane triangle to cell units, bounds it, and walks the
// box emitting every cell that passes the edge outcode test.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | word
//  ---------+-----------+----------------------+------------------------------
//  tri      | in        | tri_valid/tri_stall  | tri_word_t, one triangle
//  tile     | out       | tile_valid/tile_stall| tile_word_t, one binned cell
//  cfg      | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
//  One shared 24x24 multiplier scales the six coordinates and then forms
//  the first row base (minz times the grid width) in the base state.
//  A single-cell or oversized box then emits its word; otherwise the walk
//  tests one cell per unstalled cycle; the flush state releases the last word.
//  Reset is synchronous; the registers return to width 1, height 1, scale 2^-8.
//  A stalled tile output freezes the walk; the tri channel stalls until done.
`default_nettype none

`include "triangle_tile_binner_core_macros.svh"

module triangle_tile_binner_core #(
  parameter int MAX_SPAN = 8,
  parameter int GRID_MAX = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            tri_valid,
  output      logic                            tri_stall,
  input  wire ttb_pkg::tri_word_t              tri_word,
  output      logic                            tile_valid,
  input  wire logic                            tile_stall,
  output      ttb_pkg::tile_word_t             tile_word,
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic [ttb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ttb_pkg::INV_W-1:0]       cfg_data
);

  import ttb_pkg::*;

  localparam int DIM_W = $clog2(GRID_MAX);
  localparam int WD    = $clog2(GRID_MAX + 1);

  state_t state, state_next;

  logic [DIM_REG_W-1:0] grid_width, grid_height;
  logic [INV_W-1:0]     inv_cell_size;

  tri_word_t           tri_q;
  logic [SLOT_W-1:0]   cnt;
  logic [SLOT_W-1:0]   slot;
  logic [MUL_W-1:0]    prod;
  logic [COORD_W-1:0]  mul_a, mul_b;
  logic [COORD_W-1:0]  coord_cell [NUM_SLOTS];
  logic                frac [NUM_SLOTS];
  logic [COORD_W-1:0]  bminx, bmaxx, bminz, bmaxz;
  logic [DIM_W-1:0]    minx, maxx, minz, maxz;
  logic [DIM_W-1:0]    col, row;
  logic [TILE_W-1:0]   row_base;
  logic                pend_valid;
  logic [TILE_W-1:0]   pend_tile;

  logic [WD-1:0]       w_eff, h_eff, w_m1, h_m1;
  logic [COORD_W-1:0]  prod_cell;
  logic                out_free, single, over, hit, emit;
  tile_word_t          emit_word;
  logic [3:0]          code [3];
  logic [COORD_W-1:0]  colx, col1, rowz, row1;

  assign cfg_ready = 1'b1;
  assign tri_stall = (state != S_IDLE);
  assign out_free  = !tile_valid || !tile_stall;
  assign slot      = cnt - SLOT_W'(1);
  assign prod_cell = prod[MUL_W-1:FRAC_BITS];

  always_comb begin
    if (grid_width == '0) begin
      w_eff = WD'(1);
    end else if (32'(grid_width) > 32'(GRID_MAX)) begin
      w_eff = WD'(GRID_MAX);
    end else begin
      w_eff = WD'(grid_width);
    end
    if (grid_height == '0) begin
      h_eff = WD'(1);
    end else if (32'(grid_height) > 32'(GRID_MAX)) begin
      h_eff = WD'(GRID_MAX);
    end else begin
      h_eff = WD'(grid_height);
    end
    w_m1 = w_eff - WD'(1);
    h_m1 = h_eff - WD'(1);
  end

  always_comb begin
    mul_a = '0;
    mul_b = inv_cell_size;
    if (state == S_BASE) begin
      mul_a = COORD_W'(minz);
      mul_b = COORD_W'(w_eff);
    end else begin
      case (cnt)
        3'd0:    mul_a = tri_q.v0_x;
        3'd1:    mul_a = tri_q.v0_z;
        3'd2:    mul_a = tri_q.v1_x;
        3'd3:    mul_a = tri_q.v1_z;
        3'd4:    mul_a = tri_q.v2_x;
        3'd5:    mul_a = tri_q.v2_z;
        default: mul_a = '0;
      endcase
    end
  end

  always_comb begin
    colx = COORD_W'(col);
    col1 = colx + COORD_W'(1);
    rowz = COORD_W'(row);
    row1 = rowz + COORD_W'(1);
    for (int v = 0; v < 3; v++) begin
      code[v] = '0;
      if (coord_cell[2*v] < colx) code[v] = code[v] | OC_LEFT;
      if (coord_cell[2*v+1] < rowz) code[v] = code[v] | OC_BELOW;
      if (coord_cell[2*v] > col1 || (coord_cell[2*v] == col1 && frac[2*v])) begin
        code[v] = code[v] | OC_RIGHT;
      end
      if (coord_cell[2*v+1] > row1 || (coord_cell[2*v+1] == row1 && frac[2*v+1])) begin
        code[v] = code[v] | OC_ABOVE;
      end
    end
    hit = 1'b0;
    for (int e = 0; e < 3; e++) begin
      if ((code[EDGE_VERTEX[e]] & code[EDGE_VERTEX[e+1]]) == 4'b0000) hit = 1'b1;
    end
  end

  assign single = (minx == maxx) && (minz == maxz);
  assign over   = !single && ((32'(maxx) - 32'(minx) >= 32'(MAX_SPAN)) ||
                              (32'(maxz) - 32'(minz) >= 32'(MAX_SPAN)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    emit_word  = '{tile_index: pend_tile, owner_facet: tri_q.facet_index,
                   last_tile: 1'b0, span_overflow: 1'b0};
    unique case (state)
      S_IDLE: begin
        if (tri_valid) state_next = S_MUL;
      end
      S_MUL: begin
        if (cnt == SLOT_W'(NUM_SLOTS)) state_next = S_CLAMP;
      end
      S_CLAMP: state_next = S_BASE;
      S_BASE:  state_next = S_SETUP;
      S_SETUP: begin
        if (single || over) begin
          if (out_free) begin
            emit                    = 1'b1;
            emit_word.tile_index    = over ? '0 : prod[TILE_W-1:0] + TILE_W'(minx);
            emit_word.last_tile     = 1'b1;
            emit_word.span_overflow = over;
            state_next              = S_IDLE;
          end
        end else begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (out_free) begin
          emit = hit && pend_valid;
          if (col == maxx && row == maxz) state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          emit                = 1'b1;
          emit_word.last_tile = 1'b1;
          state_next          = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width    <= DIM_REG_W'(1);
      grid_height   <= DIM_REG_W'(1);
      inv_cell_size <= INV_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:    grid_width    <= cfg_data[DIM_REG_W-1:0];
        CFG_GRID_HEIGHT:   grid_height   <= cfg_data[DIM_REG_W-1:0];
        CFG_INV_CELL_SIZE: inv_cell_size <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_valid <= 1'b0;
    end else if (emit) begin
      tile_valid <= 1'b1;
    end else if (!tile_stall) begin
      tile_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) tile_word <= emit_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (state == S_WALK && out_free && hit) begin
      pend_valid <= 1'b1;
    end else if (state == S_FLUSH && state_next == S_IDLE) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (tri_valid) begin
          tri_q <= tri_word;
          cnt   <= '0;
        end
      end
      S_MUL: begin
        cnt <= cnt + SLOT_W'(1);
        if (cnt < SLOT_W'(NUM_SLOTS)) prod <= mul_a * mul_b;
        if (cnt != '0) begin
          coord_cell[slot] <= prod_cell;
          frac[slot]       <= |prod[FRAC_BITS-1:0];
          if (slot == SLOT_W'(0)) begin
            bminx <= prod_cell;
            bmaxx <= prod_cell;
          end else if (slot == SLOT_W'(1)) begin
            bminz <= prod_cell;
            bmaxz <= prod_cell;
          end else if (!slot[0]) begin
            if (prod_cell < bminx) bminx <= prod_cell;
            if (prod_cell > bmaxx) bmaxx <= prod_cell;
          end else begin
            if (prod_cell < bminz) bminz <= prod_cell;
            if (prod_cell > bmaxz) bmaxz <= prod_cell;
          end
        end
      end
      S_CLAMP: begin
        minx <= (bminx > COORD_W'(w_m1)) ? DIM_W'(w_m1) : DIM_W'(bminx);
        maxx <= (bmaxx > COORD_W'(w_m1)) ? DIM_W'(w_m1) : DIM_W'(bmaxx);
        minz <= (bminz > COORD_W'(h_m1)) ? DIM_W'(h_m1) : DIM_W'(bminz);
        maxz <= (bmaxz > COORD_W'(h_m1)) ? DIM_W'(h_m1) : DIM_W'(bmaxz);
      end
      S_BASE: begin
        prod <= mul_a * mul_b;
      end
      S_SETUP: begin
        col      <= minx;
        row      <= minz;
        row_base <= prod[TILE_W-1:0];
      end
      S_WALK: begin
        if (out_free) begin
          if (hit) pend_tile <= row_base + TILE_W'(col);
          if (col == maxx) begin
            col <= minx;
            if (row != maxz) begin
              row      <= row + DIM_W'(1);
              row_base <= row_base + TILE_W'(w_eff);
            end
          end else begin
            col <= col + DIM_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  `TTB_ASSERT_SAME(a_overflow_word, tile_valid && tile_word.span_overflow, tile_word.last_tile && tile_word.tile_index == '0, "overflow word must be last with tile 0")
  `TTB_ASSERT_SAME(a_walk_in_box, state == S_WALK, col >= minx && col <= maxx && row >= minz && row <= maxz, "walk position left the box")
  `TTB_ASSERT_SAME(a_pend_in_walk, pend_valid, state == S_WALK || state == S_FLUSH, "pending tile outside the walk")
  `TTB_ASSERT_NEXT(a_accept_starts, tri_valid && !tri_stall, state == S_MUL && cnt == '0, "accepted triangle did not start scaling")

endmodule

`default_nettype wire
